[rtl/etcs_pkg.sv]
// Package for the exponential Taylor coefficient unit: Q8.24 constants and the
// rounding, saturating multiply helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package etcs_pkg;
    localparam int unsigned FxW = 32;
    localparam logic signed [FxW-1:0] FxOne   = 32'sd16777216;
    localparam logic signed [FxW-1:0] FxHalf  = 32'sd8388608;
    localparam logic signed [FxW-1:0] FxSixth = 32'sd2796203;
    localparam logic signed [FxW-1:0] FxMax   = 32'sh7FFFFFFF;
    localparam logic signed [FxW-1:0] FxMin   = 32'sh80000000;

    localparam logic [1:0] RegAlpha  = 2'd0;
    localparam logic [1:0] RegScale  = 2'd1;
    localparam logic [1:0] RegOffset = 2'd2;

    typedef logic signed [FxW-1:0] t_fx;

    // Horner coefficients, index 0 is the constant term.
    function automatic t_fx poly_coef(input logic [3:0] k);
        t_fx c;
        unique case (k)
            4'd0:    c = 32'sd16777216;
            4'd1:    c = 32'sd16777209;
            4'd2:    c = 32'sd8388606;
            4'd3:    c = 32'sd2796272;
            4'd4:    c = 32'sd699062;
            4'd5:    c = 32'sd139638;
            4'd6:    c = 32'sd23279;
            4'd7:    c = 32'sd3485;
            default: c = 32'sd434;
        endcase
        return c;
    endfunction

    function automatic t_fx sat64(input logic signed [65:0] v);
        t_fx r;
        if (v > 66'sd2147483647) begin
            r = FxMax;
        end else if (v < -66'sd2147483648) begin
            r = FxMin;
        end else begin
            r = v[FxW-1:0];
        end
        return r;
    endfunction

    // Rounds a raw product (ties away from zero) by 24 bits, or by 25 bits when sh25 is set, and saturates.
    function automatic t_fx round_sat(input logic signed [65:0] p, input logic sh25);
        logic [65:0] mag;
        logic [65:0] q;
        logic signed [65:0] s;
        mag = p[65] ? 66'(-p) : 66'(p);
        q   = sh25 ? ((mag + 66'd16777216) >> 25) : ((mag + 66'd8388608) >> 24);
        s   = p[65] ? -$signed(q) : $signed(q);
        return sat64(s);
    endfunction

    function automatic t_fx fxmul(input t_fx x, input t_fx y);
        logic signed [65:0] p;
        p = 66'(x) * 66'(y);
        return round_sat(p, 1'b0);
    endfunction

    function automatic t_fx fxadd(input t_fx x, input t_fx y);
        return sat64(66'(x) + 66'(y));
    endfunction

    function automatic t_fx fxsub(input t_fx x, input t_fx y);
        return sat64(66'(x) - 66'(y));
    endfunction
endpackage
`default_nettype wire

[rtl/exp_taylor_coeff_schedule_unit.sv]
// Exponential Taylor coefficient unit, top level with its full pipeline.
// Depends on etcs_pkg for Q8.24 constants and multiply helpers.
//
// Usage: requests enter on s_axis (tdata = lower_bound, upper_bound, low word
// first) and leave on m_axis (tdata = coef_cubic, coef_quadratic, coef_linear,
// coef_constant, low word first). Registers are written on the cfg channel
// (index 0 alpha, 1 coef_scale, 2 payoff_offset), which is ready only while the
// pipeline is empty; an unknown index is acknowledged and ignored.
// The datapath is a 20-stage pipeline with at most one multiplier per stage on
// each lane: mid, an eight-step Horner chain, then coefficient products and
// the final scaling. Throughput is one request per cycle, set by the pipeline
// advancing every cycle that the output register is free or being emptied.
// When the receiver stalls, the whole pipeline holds; the input is refused
// only while the output register is full and not taken, so nothing is lost.
// Reset (synchronous, active low) clears all valid bits and loads alpha = 1.0,
// coef_scale = 1.0 and payoff_offset = 0.
`timescale 1ns / 1ps
`default_nettype none
module exp_taylor_coeff_schedule_unit
    import etcs_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [63:0]  s_axis_tdata,   // [31:0] lower_bound, [63:32] upper_bound
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [127:0] m_axis_tdata,   // cubic, quadratic, linear, constant
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data
);
    localparam int unsigned Depth = 20;

    typedef struct packed {
        t_fx mid;
        t_fx mid2;
        t_fx mid3;
        t_fx e;
        t_fx one_m;
        t_fx q1;
        t_fx q0;
        t_fx a2;
        t_fx a3;
        t_fx c3;
        t_fx c2;
        t_fx c1;
        t_fx c0;
        logic signed [32:0] sum;
    } t_slot;

    t_fx   r_alpha, r_scale, r_offset;
    t_slot r_pipe [Depth];
    t_slot n_pipe [Depth];
    logic  [Depth-1:0] r_vld;
    logic  advance;

    assign o_cfg_ready   = ~|r_vld;
    assign m_axis_tvalid = r_vld[Depth-1];
    assign advance       = !r_vld[Depth-1] || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= FxOne;
            r_scale  <= FxOne;
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                RegAlpha:  r_alpha  <= i_cfg_data;
                RegScale:  r_scale  <= i_cfg_data;
                RegOffset: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [65:0] p;
        for (int s = 0; s < Depth; s++) begin
            n_pipe[s] = (s == 0) ? r_pipe[0] : r_pipe[s-1];
        end
        // Stage 0: exact sum of the bounds.
        n_pipe[0].sum = 33'($signed(s_axis_tdata[31:0])) + 33'($signed(s_axis_tdata[63:32]));
        // Stage 1: mid, with the one half folded into the shift; alpha squared.
        p = 66'($signed(r_pipe[0].sum)) * 66'(r_alpha);
        n_pipe[1].mid = round_sat(p, 1'b1);
        n_pipe[1].a2  = fxmul(r_alpha, r_alpha);
        // Stage 2: mid squared, alpha cubed, Horner start.
        n_pipe[2].mid2 = fxmul(r_pipe[1].mid, r_pipe[1].mid);
        n_pipe[2].a3   = fxmul(r_pipe[1].a2, r_alpha);
        n_pipe[2].one_m = fxsub(FxOne, r_pipe[1].mid);
        n_pipe[2].e = fxadd(fxmul(poly_coef(4'd8), r_pipe[1].mid), poly_coef(4'd7));
        // Stages 3..9: remaining Horner steps; mid cubed and the series terms.
        for (int k = 0; k < 7; k++) begin
            n_pipe[3+k].e = fxadd(fxmul(r_pipe[2+k].e, r_pipe[2+k].mid),
                                  poly_coef(4'(6-k)));
        end
        n_pipe[3].mid3 = fxmul(r_pipe[2].mid2, r_pipe[2].mid);
        n_pipe[3].q1   = fxadd(r_pipe[2].one_m, fxmul(r_pipe[2].mid2, FxHalf));
        n_pipe[4].q0   = fxsub(r_pipe[3].q1, fxmul(r_pipe[3].mid3, FxSixth));
        n_pipe[4].one_m = fxmul(r_pipe[3].one_m, FxHalf);
        // Stage 10: Taylor coefficients.
        n_pipe[10].c3 = fxmul(r_pipe[9].e, FxSixth);
        n_pipe[10].c2 = fxmul(r_pipe[9].e, r_pipe[9].one_m);
        n_pipe[10].c1 = fxmul(r_pipe[9].e, r_pipe[9].q1);
        n_pipe[10].c0 = fxmul(r_pipe[9].e, r_pipe[9].q0);
        // Stage 11: payoff scale.
        n_pipe[11].c3 = fxmul(r_scale, r_pipe[10].c3);
        n_pipe[11].c2 = fxmul(r_scale, r_pipe[10].c2);
        n_pipe[11].c1 = fxmul(r_scale, r_pipe[10].c1);
        n_pipe[11].c0 = fxmul(r_scale, r_pipe[10].c0);
        // Stage 12: alpha powers and the offset.
        n_pipe[12].c3 = fxmul(r_pipe[11].c3, r_pipe[11].a3);
        n_pipe[12].c2 = fxmul(r_pipe[11].c2, r_pipe[11].a2);
        n_pipe[12].c1 = fxmul(r_pipe[11].c1, r_alpha);
        n_pipe[12].c0 = fxadd(r_pipe[11].c0, r_offset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int s = 0; s < Depth; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    assign m_axis_tdata = {r_pipe[Depth-1].c0, r_pipe[Depth-1].c1,
                           r_pipe[Depth-1].c2, r_pipe[Depth-1].c3};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with empty output");
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted request not tracked");
endmodule
`default_nettype wire
